>>> rtl/core/morph_pkg.sv
// shared types and constants for the 3x3 grayscale morphology block
// no dependencies; used by the interfaces and by every module of the block but morph_ram
package morph_pkg;

  localparam int PIX_W     = 8;
  localparam int COORD_W   = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // reset value of both frame dimensions
  localparam logic [CFG_W-1:0] DIM_RST = 11'd64;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef enum logic {
    MODE_ERODE  = 1'b0,
    MODE_DILATE = 1'b1
  } mode_t;

  // per-pixel result tag, computed from the counters at input transfer
  typedef struct packed {
    logic   emit;
    logic   last;
    coord_t row;
    coord_t col;
  } tag_t;

  // min for erosion, max for dilation
  function automatic pix_t pick(mode_t m, pix_t a, pix_t b);
    pix_t r;
    if (m == MODE_DILATE) begin
      r = (a > b) ? a : b;
    end else begin
      r = (a < b) ? a : b;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/morph_ifs.sv
// valid/ready channel interfaces: pixel input, result output, register writes
// depends on morph_pkg
interface morph_pix_if;
  logic              valid;
  logic              ready;
  morph_pkg::pix_t   pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface morph_res_if;
  logic              valid;
  logic              ready;
  morph_pkg::pix_t   pixel_out;
  morph_pkg::coord_t out_row;
  morph_pkg::coord_t out_col;
  logic              frame_last;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

interface morph_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [morph_pkg::CFG_IDX_W-1:0]   index;
  logic [morph_pkg::CFG_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/morph_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
module morph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/morph_cnt.sv
// configuration registers and raster position counters
// depends on morph_pkg and morph_cfg_if
module morph_cnt #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic              clk,
  input  logic              rst,
  morph_cfg_if.sink         cfg,
  input  logic              advance,
  output logic [CW-1:0]     col,
  output morph_pkg::tag_t   tag,
  output morph_pkg::mode_t  mode
);
  import morph_pkg::*;

  logic [WW-1:0] width_eff;
  logic [HW-1:0] height_eff;
  logic [RW-1:0] row;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col_m1;
  logic [RW-1:0] row_m1;
  logic          col_end;
  logic          row_end;

  function automatic logic [WW-1:0] clamp_w(logic [CFG_W-1:0] v);
    logic [WW-1:0] r;
    if (v < CFG_W'(3)) begin
      r = WW'(3);
    end else if (32'(v) > MAX_WIDTH) begin
      r = WW'(MAX_WIDTH);
    end else begin
      r = WW'(v);
    end
    return r;
  endfunction

  function automatic logic [HW-1:0] clamp_h(logic [CFG_W-1:0] v);
    logic [HW-1:0] r;
    if (v < CFG_W'(3)) begin
      r = HW'(3);
    end else if (32'(v) > MAX_HEIGHT) begin
      r = HW'(MAX_HEIGHT);
    end else begin
      r = HW'(v);
    end
    return r;
  endfunction

  assign cfg.ready = 1'b1;

  // dimensions are stored already clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_ERODE;
      width_eff  <= clamp_w(DIM_RST);
      height_eff <= clamp_h(DIM_RST);
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_MODE:   mode       <= mode_t'(cfg.data[0]);
        REG_WIDTH:  width_eff  <= clamp_w(cfg.data);
        REG_HEIGHT: height_eff <= clamp_h(cfg.data);
        default: ;
      endcase
    end
  end

  always_comb begin
    col_end  = (32'(col) + 32'd1) >= 32'(width_eff);
    row_end  = (32'(row) + 32'd1) >= 32'(height_eff);
    col_next = col_end ? '0 : col + CW'(1);
    row_next = row;
    if (col_end) begin
      row_next = row_end ? '0 : row + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // the incoming pixel closes the neighborhood centered one row and one column back
  assign col_m1 = col - CW'(1);
  assign row_m1 = row - RW'(1);

  always_comb begin
    tag.emit = (32'(row) >= 32'd2) && (32'(col) >= 32'd2) &&
               (32'(row) < 32'(height_eff)) && (32'(col) < 32'(width_eff));
    tag.last = ((32'(row) + 32'd1) == 32'(height_eff)) &&
               ((32'(col) + 32'd1) == 32'(width_eff));
    tag.row  = COORD_W'(row_m1);
    tag.col  = COORD_W'(col_m1);
  end

endmodule

>>> rtl/core/morph_win.sv
// 3x3 window registers and the min/max reduction over the shifted window
// depends on morph_pkg
module morph_win (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  morph_pkg::mode_t  mode,
  input  morph_pkg::pix_t   top,
  input  morph_pkg::pix_t   mid,
  input  morph_pkg::pix_t   bot,
  output morph_pkg::pix_t   result
);
  import morph_pkg::*;

  pix_t win [3][3];   // [row: 0 top][col: 0 oldest]
  pix_t new_col [3];

  assign new_col[0] = top;
  assign new_col[1] = mid;
  assign new_col[2] = bot;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win[k][j] <= '0;
        end
      end
    end else if (shift) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
        win[k][2] <= new_col[k];
      end
    end
  end

  // reduce over the window as it stands after this shift
  always_comb begin
    pix_t col_r [3];
    for (int k = 0; k < 3; k++) begin
      col_r[k] = pick(mode, pick(mode, win[k][1], win[k][2]), new_col[k]);
    end
    result = pick(mode, pick(mode, col_r[0], col_r[1]), col_r[2]);
  end

endmodule

>>> rtl/core/morphology_3x3_min_max.sv
// 3x3 grayscale erosion / dilation over a raster pixel stream
// path: a pixel passes the input stage and then the output register before its result appears on dst
// throughput: one pixel per cycle while dst does not stall; line store read is issued at input transfer,
//   store write-back and window shift happen when the pixel leaves the input stage
// reset: counters, window, mode and dimensions (64x64) clear at once; line
//   stores are not cleared and hold no valid data until a row has passed
module morphology_3x3_min_max #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic       clk,
  input  logic       rst,
  morph_pix_if.sink  src,
  morph_res_if.source dst,
  morph_cfg_if.sink  cfg
);
  import morph_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // position counters and registers
  logic [CW-1:0] cur_col;
  tag_t          cur_tag;
  mode_t         mode;
  logic          in_xfer;

  // input stage: the pixel waits here for the line store read data
  logic          s1_valid;
  pix_t          s1_px;
  logic [CW-1:0] s1_col;
  tag_t          s1_tag;
  logic          s1_adv;

  // line store read data: row above (mid) and two rows above (top)
  pix_t          mid;
  pix_t          top;
  pix_t          result;

  assign in_xfer   = src.valid & src.ready;
  // the stage moves on whenever the output register is free or being emptied
  assign s1_adv    = s1_valid & (~dst.valid | dst.ready);
  assign src.ready = ~s1_valid | s1_adv;

  morph_cnt #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cnt (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (in_xfer),
    .col     (cur_col),
    .tag     (cur_tag),
    .mode    (mode)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_px  <= src.pixel_in;
      s1_col <= cur_col;
      s1_tag <= cur_tag;
    end
  end

  // line store a holds the previous row; its old entry moves down into store b.
  // read happens at transfer, write-back at the same column when the pixel leaves the input stage;
  // the next read of that column is a full row away
  morph_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_a (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (s1_px),
    .re    (in_xfer),
    .raddr (cur_col),
    .rdata (mid)
  );

  morph_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_b (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (mid),
    .re    (in_xfer),
    .raddr (cur_col),
    .rdata (top)
  );

  morph_win u_win (
    .clk    (clk),
    .rst    (rst),
    .shift  (s1_adv),
    .mode   (mode),
    .top    (top),
    .mid    (mid),
    .bot    (s1_px),
    .result (result)
  );

  // output register: border pixels shift the window but produce no transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      dst.valid <= 1'b0;
    end else if (s1_adv) begin
      dst.valid <= s1_tag.emit;
    end else if (dst.ready) begin
      dst.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_tag.emit) begin
      dst.pixel_out  <= result;
      dst.out_row    <= s1_tag.row;
      dst.out_col    <= s1_tag.col;
      dst.frame_last <= s1_tag.last;
    end
  end

endmodule
